// ===== src/sbsfc_pkg.sv =====
package sbsfc_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int COEF_WIDTH_DEF   = 24;
   localparam int TRIM_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int MUL_W            = 34;
   localparam int PROD_W           = 2 * MUL_W;
   localparam int RND_W            = 44;
   localparam int STATE_W          = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_A0       = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_B1       = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_B2       = 2'd3;

   localparam longint Q30_ONE   = 64'sd1073741824;
   localparam longint Q_HALF_PI = 64'sd1686629717;
   localparam longint Q_KNEE    = 64'sd1025415481;
   localparam longint Q_K1      = 64'sd757869313;
   localparam longint Q_K2      = 64'sd280155133;
   localparam longint Q_K3      = 64'sd267546076;
   localparam longint Q_K4      = 64'sd793586583;
   localparam longint Q_S3      = 64'sd178956971;
   localparam longint Q_S5      = 64'sd8947849;
   localparam longint Q_S7      = 64'sd213044;
   localparam longint Q_S9      = 64'sd2959;

   typedef enum logic [1:0] {
      SH_TRIM,
      SH_COEF,
      SH_Q30
   } shift_type;

   typedef enum logic [5:0] {
      OP_NOP,
      OP_MT1, OP_WT1, OP_MZ2, OP_WZ2,
      OP_MP7, OP_WP7, OP_MP5, OP_WP5, OP_MP3, OP_WP3, OP_MP1, OP_WP1,
      OP_MZP, OP_WSIN,
      OP_MA0, OP_WY, OP_MA1, OP_WN1, OP_MB1, OP_WS1, OP_MB2, OP_WS2,
      OP_MT2, OP_WT2,
      OP_MC1, OP_WC1, OP_MC2, OP_WC2, OP_MC3, OP_WC3, OP_MC4, OP_WC4,
      OP_WOUT
   } op_type;

   localparam int NUM_OPS = 33;
   localparam int STEP_W  = 6;

   typedef struct packed {
      logic   load_in;
      logic   load_out;
      logic   ch;
      op_type op;
   } cmd_type;

   function automatic op_type op_at(input logic [STEP_W-1:0] step);
      return op_type'(step + 6'd1);
   endfunction

   function automatic longint to_frac_c(input longint q, input int frac);
      return (q + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
   endfunction

   function automatic logic signed [STATE_W-1:0] sat32(input logic signed [RND_W-1:0] v);
      if (v > RND_W'(64'sd2147483647)) begin
         return 32'sh7fffffff;
      end else if (v < -RND_W'(64'sd2147483648)) begin
         return 32'sh80000000;
      end
      return v[STATE_W-1:0];
   endfunction

endpackage

// ===== src/sbsfc_ctrl.sv =====
module sbsfc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output sbsfc_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [sbsfc_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                             ch_ff, ch_in;
   logic                             valid_ff, valid_in;
   logic                             last_step;

   assign last_step  = (step_ff == sbsfc_pkg::STEP_W'(sbsfc_pkg::NUM_OPS - 1));
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ch_in        = ch_ff;
      valid_in     = valid_ff & ~rsp_tready;
      cmd.load_in  = 1'b0;
      cmd.load_out = 1'b0;
      cmd.ch       = ch_ff;
      cmd.op       = sbsfc_pkg::OP_NOP;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               step_in     = '0;
               ch_in       = 1'b0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.op  = sbsfc_pkg::op_at(step_ff);
            step_in = step_ff + 1'b1;
            if (last_step) begin
               step_in = '0;
               ch_in   = 1'b1;
               if (ch_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         ch_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ch_ff    <= ch_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== src/sbsfc_dp.sv =====
module sbsfc_dp #(
   parameter int SAMPLE_WIDTH = sbsfc_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = sbsfc_pkg::COEF_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sbsfc_pkg::cmd_type                   cmd,
   input  logic signed [SAMPLE_WIDTH-1:0]       left_in,
   input  logic signed [SAMPLE_WIDTH-1:0]       right_in,
   input  logic [sbsfc_pkg::TRIM_WIDTH-1:0]     trim,
   input  logic                                 csr_wr_en,
   input  logic [sbsfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]                csr_wdata,
   output logic signed [SAMPLE_WIDTH-1:0]       left_out,
   output logic signed [SAMPLE_WIDTH-1:0]       right_out
);

   localparam int MW    = sbsfc_pkg::MUL_W;
   localparam int RW    = sbsfc_pkg::RND_W;
   localparam int PW    = sbsfc_pkg::PROD_W;
   localparam int SW    = sbsfc_pkg::STATE_W;
   localparam int FRAC  = SAMPLE_WIDTH - 4;
   localparam int CFRAC = COEF_WIDTH - 3;
   localparam int ZSH   = 30 - FRAC;

   localparam longint HP   = sbsfc_pkg::to_frac_c(sbsfc_pkg::Q_HALF_PI, FRAC);
   localparam longint FOUR = 64'sd4 <<< FRAC;
   localparam longint KNEE = sbsfc_pkg::to_frac_c(sbsfc_pkg::Q_KNEE, FRAC);
   localparam longint K1   = sbsfc_pkg::to_frac_c(sbsfc_pkg::Q_K1, FRAC);
   localparam longint K3   = sbsfc_pkg::to_frac_c(sbsfc_pkg::Q_K3, FRAC);

   logic                           en_ff;
   logic signed [COEF_WIDTH-1:0]   a0_ff, b1_ff, b2_ff;
   logic signed [SAMPLE_WIDTH-1:0] inl_ff, inr_ff;
   logic [sbsfc_pkg::TRIM_WIDTH-1:0] trim_ff;
   logic signed [PW-1:0]           prod_ff, prod_in;
   sbsfc_pkg::shift_type           sh_ff;
   logic                           cond_ff;
   logic signed [MW-1:0]           x_ff, z2_ff, p_ff, y_ff, t_ff;
   logic signed [RW-1:0]           acc_ff;
   logic signed [SW-1:0]           s1_ff [2];
   logic signed [SW-1:0]           s2_ff [2];
   logic signed [SAMPLE_WIDTH-1:0] held_ff [2];
   logic [1:0]                     flags_ff [2];
   logic signed [SAMPLE_WIDTH-1:0] outl_ff, outr_ff, left_ff, right_ff;

   logic signed [MW-1:0]           mul_a, mul_b, z, xin, heldx, trimx;
   logic signed [PW-1:0]           rsum;
   logic signed [RW-1:0]           rnd, sinc, sin_acc;
   logic                           ch, c_lt, c_gt;
   sbsfc_pkg::shift_type           sh_in;

   assign ch    = cmd.ch;
   assign xin   = ch ? MW'(inr_ff) : MW'(inl_ff);
   assign heldx = MW'(held_ff[ch]);
   assign trimx = MW'(trim_ff);
   assign z     = x_ff <<< ZSH;
   assign c_lt  = x_ff < heldx;
   assign c_gt  = x_ff > heldx;
   assign left_out  = left_ff;
   assign right_out = right_ff;

   always_comb begin
      mul_a = x_ff;
      mul_b = trimx;
      sh_in = sbsfc_pkg::SH_Q30;
      case (cmd.op)
         sbsfc_pkg::OP_MT1: begin
            mul_a = xin;
            sh_in = sbsfc_pkg::SH_TRIM;
         end
         sbsfc_pkg::OP_MT2: sh_in = sbsfc_pkg::SH_TRIM;
         sbsfc_pkg::OP_MZ2: begin
            mul_a = z;
            mul_b = z;
         end
         sbsfc_pkg::OP_MP7, sbsfc_pkg::OP_MP5, sbsfc_pkg::OP_MP3, sbsfc_pkg::OP_MP1: begin
            mul_a = p_ff;
            mul_b = z2_ff;
         end
         sbsfc_pkg::OP_MZP: begin
            mul_a = z;
            mul_b = p_ff;
         end
         sbsfc_pkg::OP_MA0: begin
            mul_b = MW'(a0_ff);
            sh_in = sbsfc_pkg::SH_COEF;
         end
         sbsfc_pkg::OP_MA1: begin
            mul_b = MW'(a0_ff) <<< 1;
            sh_in = sbsfc_pkg::SH_COEF;
         end
         sbsfc_pkg::OP_MB1: begin
            mul_a = y_ff;
            mul_b = MW'(b1_ff);
            sh_in = sbsfc_pkg::SH_COEF;
         end
         sbsfc_pkg::OP_MB2: begin
            mul_a = y_ff;
            mul_b = MW'(b2_ff);
            sh_in = sbsfc_pkg::SH_COEF;
         end
         sbsfc_pkg::OP_MC1: begin
            mul_a = c_lt ? x_ff : heldx;
            mul_b = c_lt ? MW'(sbsfc_pkg::Q_K2) : MW'(sbsfc_pkg::Q_K4);
         end
         sbsfc_pkg::OP_MC3: begin
            mul_a = c_gt ? x_ff : heldx;
            mul_b = c_gt ? MW'(sbsfc_pkg::Q_K2) : MW'(sbsfc_pkg::Q_K4);
         end
         sbsfc_pkg::OP_MC2, sbsfc_pkg::OP_MC4: begin
            mul_a = heldx;
            mul_b = MW'(sbsfc_pkg::Q_K2);
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      case (sh_ff)
         sbsfc_pkg::SH_TRIM: begin
            rsum = prod_ff + (PW'(1) <<< 14);
            rnd  = RW'(rsum >>> 15);
         end
         sbsfc_pkg::SH_COEF: begin
            rsum = prod_ff + (PW'(1) <<< (CFRAC - 1));
            rnd  = RW'(rsum >>> CFRAC);
         end
         default: begin
            rsum = prod_ff + (PW'(1) <<< 29);
            rnd  = RW'(rsum >>> 30);
         end
      endcase
      if (rnd > RW'(sbsfc_pkg::Q30_ONE)) begin
         sinc = RW'(sbsfc_pkg::Q30_ONE);
      end else if (rnd < -RW'(sbsfc_pkg::Q30_ONE)) begin
         sinc = -RW'(sbsfc_pkg::Q30_ONE);
      end else begin
         sinc = rnd;
      end
      sin_acc = (sinc + (RW'(1) <<< (ZSH - 1))) >>> ZSH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff       <= 1'b0;
         a0_ff       <= '0;
         b1_ff       <= '0;
         b2_ff       <= '0;
         s1_ff[0]    <= '0;
         s1_ff[1]    <= '0;
         s2_ff[0]    <= '0;
         s2_ff[1]    <= '0;
         held_ff[0]  <= '0;
         held_ff[1]  <= '0;
         flags_ff[0] <= '0;
         flags_ff[1] <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               sbsfc_pkg::CSR_FILTER_ENABLE: en_ff <= csr_wdata[0];
               sbsfc_pkg::CSR_COEF_A0:       a0_ff <= csr_wdata;
               sbsfc_pkg::CSR_COEF_B1:       b1_ff <= csr_wdata;
               sbsfc_pkg::CSR_COEF_B2:       b2_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (cmd.op)
            sbsfc_pkg::OP_WY: begin
               if (en_ff) begin
                  y_ff <= MW'(sbsfc_pkg::sat32(rnd + RW'(s1_ff[ch])));
                  t_ff <= MW'(rnd);
               end
            end
            sbsfc_pkg::OP_WN1: acc_ff <= rnd + RW'(s2_ff[ch]);
            sbsfc_pkg::OP_WS1: begin
               if (en_ff) begin
                  s1_ff[ch] <= sbsfc_pkg::sat32(acc_ff - rnd);
               end
            end
            sbsfc_pkg::OP_WS2: begin
               if (en_ff) begin
                  s2_ff[ch] <= sbsfc_pkg::sat32(RW'(t_ff) - rnd);
               end
            end
            sbsfc_pkg::OP_WC1: begin
               if (flags_ff[ch][0]) begin
                  held_ff[ch] <= SAMPLE_WIDTH'((cond_ff ? RW'(K1) : RW'(K3)) + rnd);
               end
            end
            sbsfc_pkg::OP_WC2: flags_ff[ch][0] <= (x_ff > MW'(KNEE));
            sbsfc_pkg::OP_WC3: begin
               if (flags_ff[ch][1]) begin
                  held_ff[ch] <= SAMPLE_WIDTH'((cond_ff ? -RW'(K1) : -RW'(K3)) + rnd);
               end
            end
            sbsfc_pkg::OP_WC4: flags_ff[ch][1] <= (x_ff < -MW'(KNEE));
            sbsfc_pkg::OP_WOUT: held_ff[ch] <= SAMPLE_WIDTH'(x_ff);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sh_ff   <= sh_in;
      if (cmd.op == sbsfc_pkg::OP_MC1) begin
         cond_ff <= c_lt;
      end else if (cmd.op == sbsfc_pkg::OP_MC3) begin
         cond_ff <= c_gt;
      end
      if (cmd.load_in) begin
         inl_ff  <= left_in;
         inr_ff  <= right_in;
         trim_ff <= trim;
      end
      if (cmd.load_out) begin
         left_ff  <= outl_ff;
         right_ff <= outr_ff;
      end
      case (cmd.op)
         sbsfc_pkg::OP_WT1: begin
            if (rnd > RW'(HP)) begin
               x_ff <= MW'(HP);
            end else if (rnd < -RW'(HP)) begin
               x_ff <= -MW'(HP);
            end else begin
               x_ff <= MW'(rnd);
            end
         end
         sbsfc_pkg::OP_WZ2: begin
            z2_ff <= MW'(rnd);
            p_ff  <= MW'(sbsfc_pkg::Q_S9);
         end
         sbsfc_pkg::OP_WP7: p_ff <= MW'(rnd - RW'(sbsfc_pkg::Q_S7));
         sbsfc_pkg::OP_WP5: p_ff <= MW'(rnd + RW'(sbsfc_pkg::Q_S5));
         sbsfc_pkg::OP_WP3: p_ff <= MW'(rnd - RW'(sbsfc_pkg::Q_S3));
         sbsfc_pkg::OP_WP1: p_ff <= MW'(rnd + RW'(sbsfc_pkg::Q30_ONE));
         sbsfc_pkg::OP_WSIN: x_ff <= MW'(sin_acc);
         sbsfc_pkg::OP_WS2: begin
            if (en_ff) begin
               x_ff <= y_ff;
            end
         end
         sbsfc_pkg::OP_WT2: begin
            if (rnd > RW'(FOUR)) begin
               x_ff <= MW'(FOUR);
            end else if (rnd < -RW'(FOUR)) begin
               x_ff <= -MW'(FOUR);
            end else begin
               x_ff <= MW'(rnd);
            end
         end
         sbsfc_pkg::OP_WC2: begin
            if (x_ff > MW'(KNEE)) begin
               x_ff <= MW'(RW'(K1) + rnd);
            end
         end
         sbsfc_pkg::OP_WC4: begin
            if (x_ff < -MW'(KNEE)) begin
               x_ff <= MW'(rnd - RW'(K1));
            end
         end
         sbsfc_pkg::OP_WOUT: begin
            if (ch) begin
               outr_ff <= held_ff[ch];
            end else begin
               outl_ff <= held_ff[ch];
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== src/stereo_bus_saturate_filter_clip.sv =====
// Channel   Direction  Word fields (low bit up)
// req_      in         left_in, right_in, trim
// rsp_      out        left_out, right_out
// csr_      in         0 filter_enable, 1 coef_a0, 2 coef_b1, 3 coef_b2
//
// A frame is accepted, then runs 33 steps per channel of the shared
// 34x34 multiplier and its round/clamp stage, then loads the result register.
// Reset clears the filter states, held samples, clip flags and CSR registers.
// A finished result waits in the output register while the next frame runs;
// the block stalls only when that register is still full at the end of a frame.
module stereo_bus_saturate_filter_clip #(
   parameter int SAMPLE_WIDTH = sbsfc_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = sbsfc_pkg::COEF_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // left_in, right_in, trim
   input  logic [((2 * SAMPLE_WIDTH + sbsfc_pkg::TRIM_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // left_out, right_out
   output logic [((2 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                  csr_wr_en,
   input  logic [sbsfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]                 csr_wdata
);

   localparam int REQ_BITS = 2 * SAMPLE_WIDTH + sbsfc_pkg::TRIM_WIDTH;
   localparam int RSP_W    = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

   sbsfc_pkg::cmd_type             cmd;
   logic signed [SAMPLE_WIDTH-1:0] left_out, right_out;

   sbsfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   sbsfc_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .left_in   (req_tdata[SAMPLE_WIDTH-1:0]),
      .right_in  (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .trim      (req_tdata[REQ_BITS-1:2*SAMPLE_WIDTH]),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .left_out  (left_out),
      .right_out (right_out)
   );

   assign rsp_tdata = RSP_W'({right_out, left_out});

endmodule

// ===== test/stereo_bus_saturate_filter_clip_tb.sv =====
module stereo_bus_saturate_filter_clip_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW      = 24;
   localparam int FR      = SW - 4;
   localparam int CF      = 21;
   localparam int REQ_W   = 64;
   localparam int RSP_W   = 48;
   localparam int WD_LIMIT = 20000;

   typedef struct {
      logic [SW-1:0] left_s;
      logic [SW-1:0] right_s;
   } frame_type;

   typedef struct {
      longint s1;
      longint s2;
      longint held;
      logic [1:0] flags;
   } chan_type;

   typedef struct {
      logic [SW-1:0] l;
      logic [SW-1:0] r;
      logic [15:0]   trim;
      bit            fixed;
      logic [SW-1:0] exp_l;
      logic [SW-1:0] exp_r;
   } vec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;  // left_in, right_in, trim
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;       // left_out, right_out
   logic csr_wr_en = 1'b0;
   logic [sbsfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;

   bit        filt_on;
   longint    a0, b1, b2;
   chan_type  chans[2];
   frame_type expected_frames[$];
   int        fail_count = 0;
   int        words_in = 0;
   int        words_out = 0;
   int        idle_cycles = 0;
   bit        no_idle = 1'b0;
   vec_type   vecs[$];

   stereo_bus_saturate_filter_clip uut (.*);

   always #4 clock = ~clock;

   function automatic longint rshift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clampv(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint q30_frac(longint q);
      return rshift(q, 30 - FR);
   endfunction

   function automatic longint sine_q(longint x);
      longint z, z2, p;
      z  = x <<< (30 - FR);
      z2 = rshift(z * z, 30);
      p  = sbsfc_pkg::Q_S9;
      p  = rshift(p * z2, 30) - sbsfc_pkg::Q_S7;
      p  = rshift(p * z2, 30) + sbsfc_pkg::Q_S5;
      p  = rshift(p * z2, 30) - sbsfc_pkg::Q_S3;
      p  = rshift(p * z2, 30) + sbsfc_pkg::Q30_ONE;
      return q30_frac(clampv(rshift(z * p, 30), -sbsfc_pkg::Q30_ONE, sbsfc_pkg::Q30_ONE));
   endfunction

   function automatic longint shape_sample(int ch, longint x, longint trim);
      longint hp, four, knee, k1, k3, y, n1, n2, held_out;
      hp   = q30_frac(sbsfc_pkg::Q_HALF_PI);
      four = 64'sd4 <<< FR;
      knee = q30_frac(sbsfc_pkg::Q_KNEE);
      k1   = q30_frac(sbsfc_pkg::Q_K1);
      k3   = q30_frac(sbsfc_pkg::Q_K3);
      x = clampv(rshift(x * trim, 15), -hp, hp);
      x = sine_q(x);
      if (filt_on) begin
         y  = clampv(rshift(x * a0, CF) + chans[ch].s1, -64'sd2147483648, 64'sd2147483647);
         n1 = rshift(x * (2 * a0), CF) - rshift(y * b1, CF) + chans[ch].s2;
         n2 = rshift(x * a0, CF) - rshift(y * b2, CF);
         chans[ch].s1 = clampv(n1, -64'sd2147483648, 64'sd2147483647);
         chans[ch].s2 = clampv(n2, -64'sd2147483648, 64'sd2147483647);
         x = y;
      end
      x = clampv(rshift(x * trim, 15), -four, four);
      if (chans[ch].flags[0]) begin
         if (x < chans[ch].held) chans[ch].held = k1 + rshift(x * sbsfc_pkg::Q_K2, 30);
         else chans[ch].held = k3 + rshift(chans[ch].held * sbsfc_pkg::Q_K4, 30);
      end
      chans[ch].flags[0] = 1'b0;
      if (x > knee) begin
         chans[ch].flags[0] = 1'b1;
         x = k1 + rshift(chans[ch].held * sbsfc_pkg::Q_K2, 30);
      end
      if (chans[ch].flags[1]) begin
         if (x > chans[ch].held) chans[ch].held = -k1 + rshift(x * sbsfc_pkg::Q_K2, 30);
         else chans[ch].held = -k3 + rshift(chans[ch].held * sbsfc_pkg::Q_K4, 30);
      end
      chans[ch].flags[1] = 1'b0;
      if (x < -knee) begin
         chans[ch].flags[1] = 1'b1;
         x = -k1 + rshift(chans[ch].held * sbsfc_pkg::Q_K2, 30);
      end
      held_out = chans[ch].held;
      chans[ch].held = x;
      return held_out;
   endfunction

   function automatic frame_type predict_frame(logic [SW-1:0] l, logic [SW-1:0] r,
                                               logic [15:0] trim);
      frame_type f;
      f.left_s  = SW'(shape_sample(0, longint'($signed(l)), longint'(trim)));
      f.right_s = SW'(shape_sample(1, longint'($signed(r)), longint'(trim)));
      return f;
   endfunction

   task automatic write_csr(logic [sbsfc_pkg::CSR_INDEX_WIDTH-1:0] idx, logic [23:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         sbsfc_pkg::CSR_FILTER_ENABLE: filt_on = val[0];
         sbsfc_pkg::CSR_COEF_A0:       a0 = longint'($signed(val));
         sbsfc_pkg::CSR_COEF_B1:       b1 = longint'($signed(val));
         sbsfc_pkg::CSR_COEF_B2:       b2 = longint'($signed(val));
         default: ;
      endcase
   endtask

   task automatic drain_wait();
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic send_frame(logic [SW-1:0] l, logic [SW-1:0] r, logic [15:0] trim);
      while (!no_idle && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {16'd0, trim, r, l};
      expected_frames.push_back(predict_frame(l, r, trim));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_in++;
      @(negedge clock);
   endtask

   task automatic send_random(int count);
      logic [SW-1:0] l, r;
      logic [15:0] t;
      repeat (count) begin
         l = SW'($urandom);
         r = SW'($urandom);
         case ($urandom_range(3))
            0: t = 16'($urandom);
            1: t = 16'd32768;
            2: t = 16'($urandom_range(16000, 40000));
            default: t = 16'($urandom_range(40000, 65535));
         endcase
         if ($urandom_range(3) == 0) begin
            l = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
         end
         send_frame(l, r, t);
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 30);
   end

   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_out++;
         if (expected_frames.size() == 0) begin
            $error("unexpected word %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_frames.pop_front();
            if (rsp_tdata[SW-1:0] !== want.left_s) begin
               $error("left_out expected %h actual %h", want.left_s, rsp_tdata[SW-1:0]);
               fail_count++;
            end
            if (rsp_tdata[2*SW-1:SW] !== want.right_s) begin
               $error("right_out expected %h actual %h", want.right_s,
                      rsp_tdata[2*SW-1:SW]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("[stereo_bus_saturate_filter_clip] ERROR");
         $finish;
      end
   end

   task automatic add_vec(logic [SW-1:0] l, logic [SW-1:0] r, logic [15:0] t,
                          bit fixed, logic [SW-1:0] el, logic [SW-1:0] er);
      vec_type v;
      v.l = l; v.r = r; v.trim = t; v.fixed = fixed; v.exp_l = el; v.exp_r = er;
      vecs.push_back(v);
   endtask

   task automatic run_table();
      frame_type f;
      foreach (vecs[i]) begin
         send_frame(vecs[i].l, vecs[i].r, vecs[i].trim);
         if (vecs[i].fixed) begin
            f = expected_frames[$];
            if (f.left_s !== vecs[i].exp_l) begin
               $error("table row %0d left_out expected %h actual %h", i,
                      vecs[i].exp_l, f.left_s);
               fail_count++;
            end
            if (f.right_s !== vecs[i].exp_r) begin
               $error("table row %0d right_out expected %h actual %h", i,
                      vecs[i].exp_r, f.right_s);
               fail_count++;
            end
         end
      end
   endtask

   initial begin
      filt_on = 0; a0 = 0; b1 = 0; b2 = 0;
      for (int c = 0; c < 2; c++) chans[c] = '{0, 0, 0, 2'b00};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset the held samples are zero
      add_vec(24'h0, 24'h0, 16'd32768, 1, 24'h0, 24'h0);
      add_vec(24'h7fffff, 24'h800000, 16'd32768, 1, 24'h0, 24'h0);
      add_vec(24'h7fffff, 24'h800000, 16'hffff, 0, 0, 0);
      add_vec(24'h800000, 24'h7fffff, 16'hffff, 0, 0, 0);
      add_vec(24'h7fffff, 24'h7fffff, 16'hffff, 0, 0, 0);
      add_vec(24'h100000, 24'hf00000, 16'h0000, 0, 0, 0);
      add_vec(24'h0c0000, 24'hf40000, 16'h7fff, 0, 0, 0);
      add_vec(24'h0fffff, 24'hf00001, 16'hc000, 0, 0, 0);
      add_vec(24'h000001, 24'hffffff, 16'h0001, 0, 0, 0);
      add_vec(24'h155555, 24'heaaaab, 16'h8000, 0, 0, 0);
      add_vec(24'h800000, 24'h800000, 16'hffff, 0, 0, 0);
      run_table();
      drain_wait();

      write_csr(sbsfc_pkg::CSR_COEF_A0, 24'd4300);
      write_csr(sbsfc_pkg::CSR_COEF_B1, 24'hc80000);
      write_csr(sbsfc_pkg::CSR_COEF_B2, 24'd1350000);
      write_csr(sbsfc_pkg::CSR_FILTER_ENABLE, 24'd1);
      send_random(250);
      drain_wait();

      write_csr(sbsfc_pkg::CSR_COEF_A0, 24'h7fffff);
      write_csr(sbsfc_pkg::CSR_COEF_B1, 24'h800000);
      write_csr(sbsfc_pkg::CSR_COEF_B2, 24'h7fffff);
      send_random(150);
      drain_wait();

      write_csr(sbsfc_pkg::CSR_COEF_A0, 24'h800000);
      write_csr(sbsfc_pkg::CSR_COEF_B1, 24'h7fffff);
      write_csr(sbsfc_pkg::CSR_COEF_B2, 24'h800000);
      no_idle = 1'b1;
      send_random(150);
      no_idle = 1'b0;
      drain_wait();

      write_csr(sbsfc_pkg::CSR_FILTER_ENABLE, 24'd0);
      send_random(250);
      drain_wait();

      write_csr(sbsfc_pkg::CSR_COEF_A0, 24'($urandom));
      write_csr(sbsfc_pkg::CSR_COEF_B1, 24'($urandom));
      write_csr(sbsfc_pkg::CSR_COEF_B2, 24'($urandom));
      write_csr(sbsfc_pkg::CSR_FILTER_ENABLE, 24'hffffff);
      send_random(240);
      drain_wait();

      $display("Covered %0d frames in, %0d out, filter on and off, extreme coefficients.",
               words_in, words_out);
      if (fail_count == 0) begin
         $display("[stereo_bus_saturate_filter_clip] OK");
      end else begin
         $display("[stereo_bus_saturate_filter_clip] ERROR");
      end
      $finish;
   end
endmodule

// ===== files.f =====
src/sbsfc_pkg.sv
src/sbsfc_ctrl.sv
src/sbsfc_dp.sv
src/stereo_bus_saturate_filter_clip.sv
test/stereo_bus_saturate_filter_clip_tb.sv
